[rtl/hrc_pkg.sv]
// ----------------------------------------------------------------------------
// hrc_pkg
// shared types, action codes and constant-divisor helpers for the converter
// ----------------------------------------------------------------------------
package hrc_pkg;

    // action codes carried on s_tuser
    localparam logic [1:0] ACT_TO_HSV = 2'd0;
    localparam logic [1:0] ACT_TO_RGB = 2'd1;
    localparam logic [1:0] ACT_VIVID  = 2'd2;
    localparam logic [1:0] ACT_UNDEF  = 2'd3;

    localparam logic [10:0] HUE_WRAP  = 11'd360;
    localparam logic [7:0]  HUE_GREEN = 8'd120;
    localparam logic [7:0]  HUE_BLUE  = 8'd240;
    localparam logic [7:0]  FULL_SCALE = 8'd255;
    localparam logic [6:0]  SECTOR_DEG = 7'd60;

    // per-pixel side data that rides along the divider stages
    typedef struct packed {
        logic [1:0] act;
        logic [7:0] base;
        logic       neg;
        logic       dz;
        logic       mz;
        logic [7:0] vmax;
        logic [8:0] hin;
        logic [7:0] sin;
        logic [7:0] vin;
    } hrc_side_t;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } hrc_hsv_t;

    // action plus the finished hsv result, carried to the output
    typedef struct packed {
        logic [1:0] act;
        hrc_hsv_t   hsv;
    } hrc_carry_t;

    // floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [25:0] prod;
        prod = 26'({1'b0, x} + 17'd1) * 26'd257;
        return prod[23:16];
    endfunction

    // floor(x / 60) for x up to 255*60
    function automatic logic [7:0] div60(input logic [13:0] x);
        logic [28:0] prod;
        prod = 29'(x) * 29'd17477;
        return prod[27:20];
    endfunction

endpackage

[rtl/hrc_div.sv]
// ----------------------------------------------------------------------------
// hrc_div
// pipelined restoring divider, 16-bit dividend by 8-bit divisor, two quotient
// bits per stage; the dividend must stay below 256 times the divisor
// ----------------------------------------------------------------------------
module hrc_div (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] dvd,
    input  logic [7:0]  dvs,
    output logic [7:0]  quo
);

    localparam int NSTG = 4;

    logic [15:0] rem_reg [NSTG-1];
    logic [7:0]  dvs_reg [NSTG-1];
    logic [7:0]  quo_reg [NSTG];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stg
            localparam int SH = 7 - 2 * k;
            logic [15:0] rem_in;
            logic [7:0]  dvs_in;
            logic [7:0]  quo_in;
            logic [15:0] rem_mid;
            logic [15:0] rem_next;
            logic [7:0]  quo_next;
            logic [15:0] trial_hi;
            logic [15:0] trial_lo;

            if (k == 0)
            begin : g_first
                assign rem_in = dvd;
                assign dvs_in = dvs;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            always_comb
            begin
                trial_hi = 16'(dvs_in) << SH;
                trial_lo = 16'(dvs_in) << (SH - 1);
                rem_mid  = rem_in;
                quo_next = quo_in;
                if (rem_in >= trial_hi)
                begin
                    rem_mid      = rem_in - trial_hi;
                    quo_next[SH] = 1'b1;
                end
                rem_next = rem_mid;
                if (rem_mid >= trial_lo)
                begin
                    rem_next         = rem_mid - trial_lo;
                    quo_next[SH - 1] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[k] <= quo_next;
                end
            end

            if (k < NSTG - 1)
            begin : g_fwd
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k] <= rem_next;
                        dvs_reg[k] <= dvs_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NSTG-1];

endmodule

[rtl/hsv_rgb_color_converter_top.sv]
// ----------------------------------------------------------------------------
// hsv_rgb_color_converter_top
// rgb888 / hsv converter with a vivid brightness recolor mode
// ----------------------------------------------------------------------------
// One word per clock in and out while nothing stalls. Each word runs through
// a fixed 12-stage pipeline that holds the two pipelined dividers (hue and
// saturation, 4 stages each). The whole pipeline advances together: when
// the output word is held by m_tready low the pipeline freezes and s_tready
// drops, and with m_tready high a new word is taken every cycle. s_tuser
// picks the action: 0 rgb to hsv, 1 hsv to rgb, 2 vivid brightness (rgb in,
// saturation forced full, value scaled by brightness_level/255, rgb out).
// Fields an action does not produce come out zero; action code 3 gives an
// all-zero word. brightness_level resets to 255 and should only be written
// while no word is in flight.
module hsv_rgb_color_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: brightness_level
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // red_in, green_in, blue_in, hue_in, sat_in, val_in
    input  logic [1:0]  s_tuser,   // action
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // hue_out, sat_out, val_out, red_out, green_out, blue_out
);

    localparam int NSTAGE = 12;
    localparam int NSIDE  = 4;

    logic [7:0]        bright_reg;
    logic [NSTAGE-1:0] vld_reg;
    logic              en;

    // global advance: move when the output slot is empty or being taken
    assign en       = !vld_reg[NSTAGE-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= hrc_pkg::FULL_SCALE;
        end
        else if (cfg_we)
        begin
            bright_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_tvalid};
        end
    end

    // ---------------- stage 1: max, min, hue difference ----------------
    logic [7:0] in_r, in_g, in_b;
    logic [7:0] mx, mn, delta, pa, pb, mag;
    hrc_pkg::hrc_side_t side_next;

    assign in_r = s_tdata[7:0];
    assign in_g = s_tdata[15:8];
    assign in_b = s_tdata[23:16];

    always_comb
    begin
        mx = in_r;
        mn = in_r;
        if (in_g > mx) mx = in_g;
        if (in_b > mx) mx = in_b;
        if (in_g < mn) mn = in_g;
        if (in_b < mn) mn = in_b;
        delta = mx - mn;
        side_next.base = '0;
        // red wins ties, then green
        if (mx == in_r)
        begin
            pa = in_g;
            pb = in_b;
        end
        else if (mx == in_g)
        begin
            pa = in_b;
            pb = in_r;
            side_next.base = hrc_pkg::HUE_GREEN;
        end
        else
        begin
            pa = in_r;
            pb = in_g;
            side_next.base = hrc_pkg::HUE_BLUE;
        end
        side_next.neg  = pa < pb;
        mag            = side_next.neg ? (pb - pa) : (pa - pb);
        side_next.act  = s_tuser;
        side_next.dz   = delta == '0;
        side_next.mz   = mx == '0;
        side_next.vmax = mx;
        side_next.hin  = s_tdata[32:24];
        side_next.sin  = s_tdata[40:33];
        side_next.vin  = s_tdata[48:41];
    end

    hrc_pkg::hrc_side_t s1_side_reg;
    logic [15:0]        s1_hdvd_reg;
    logic [15:0]        s1_sdvd_reg;
    logic [7:0]         s1_delta_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg  <= side_next;
            s1_hdvd_reg  <= 16'(mag) * 16'd60;
            s1_sdvd_reg  <= 16'(delta) * 16'(hrc_pkg::FULL_SCALE);
            s1_delta_reg <= delta;
        end
    end

    // ---------------- stages 2..5: hue and saturation dividers ----------------
    logic [7:0] hquo, squo;

    hrc_div u_hdiv (
        .clk (clk),
        .en  (en),
        .dvd (s1_hdvd_reg),
        .dvs (s1_delta_reg),
        .quo (hquo)
    );

    hrc_div u_sdiv (
        .clk (clk),
        .en  (en),
        .dvd (s1_sdvd_reg),
        .dvs (s1_side_reg.vmax),
        .quo (squo)
    );

    hrc_pkg::hrc_side_t side_reg [NSIDE];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s1_side_reg;
            for (int i = 1; i < NSIDE; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- stage 6: hue wrap, saturation, value scale ----------------
    hrc_pkg::hrc_side_t sd;
    logic [10:0]        hsum;
    hrc_pkg::hrc_hsv_t  hsv_next;

    assign sd = side_reg[NSIDE-1];

    always_comb
    begin
        if (sd.neg)
            hsum = 11'(sd.base) + hrc_pkg::HUE_WRAP - 11'(hquo);
        else
            hsum = 11'(sd.base) + hrc_pkg::HUE_WRAP + 11'(hquo);
        if (hsum >= hrc_pkg::HUE_WRAP)
            hsum = hsum - hrc_pkg::HUE_WRAP;
        hsv_next.hue = sd.dz ? '0 : hsum[8:0];
        hsv_next.sat = sd.mz ? '0 : squo;
        hsv_next.val = sd.vmax;
    end

    logic [1:0]         s6_act_reg;
    hrc_pkg::hrc_hsv_t  s6_hsv_reg;
    hrc_pkg::hrc_hsv_t  s6_x_reg;
    logic [15:0]        s6_vprod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_act_reg   <= sd.act;
            s6_hsv_reg   <= hsv_next;
            s6_x_reg     <= '{hue: sd.hin, sat: sd.sin, val: sd.vin};
            s6_vprod_reg <= 16'(sd.vmax) * 16'(bright_reg);
        end
    end

    // ---------------- stage 7: pick hsv source for the rgb half ----------------
    hrc_pkg::hrc_carry_t s7_carry_reg;
    hrc_pkg::hrc_hsv_t   s7_x_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_carry_reg.act <= s6_act_reg;
            s7_carry_reg.hsv <= (s6_act_reg == hrc_pkg::ACT_TO_HSV) ? s6_hsv_reg : '0;
            if (s6_act_reg == hrc_pkg::ACT_VIVID)
                s7_x_reg <= '{hue: s6_hsv_reg.hue, sat: hrc_pkg::FULL_SCALE,
                              val: hrc_pkg::div255(s6_vprod_reg)};
            else
                s7_x_reg <= s6_x_reg;
        end
    end

    // ---------------- stage 8: sector and remainder ----------------
    logic [7:0] sec_full;
    logic [9:0] sec_deg;

    assign sec_full = hrc_pkg::div60(14'(s7_x_reg.hue));
    assign sec_deg  = 10'(sec_full[3:0]) * 10'(hrc_pkg::SECTOR_DEG);

    hrc_pkg::hrc_carry_t s8_carry_reg;
    hrc_pkg::hrc_hsv_t   s8_x_reg;
    logic [3:0]          s8_sector_reg;
    logic [5:0]          s8_rem_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_carry_reg  <= s7_carry_reg;
            s8_x_reg      <= s7_x_reg;
            s8_sector_reg <= sec_full[3:0];
            s8_rem_reg    <= 6'(10'(s7_x_reg.hue) - sec_deg);
        end
    end

    // ---------------- stage 9: p, q, t products ----------------
    hrc_pkg::hrc_carry_t s9_carry_reg;
    logic [7:0]          s9_v_reg;
    logic                s9_szero_reg;
    logic [3:0]          s9_sector_reg;
    logic [13:0]         s9_sr_reg;
    logic [13:0]         s9_st_reg;
    logic [15:0]         s9_pnum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_carry_reg  <= s8_carry_reg;
            s9_v_reg      <= s8_x_reg.val;
            s9_szero_reg  <= s8_x_reg.sat == '0;
            s9_sector_reg <= s8_sector_reg;
            s9_sr_reg     <= 14'(s8_x_reg.sat) * 14'(s8_rem_reg);
            s9_st_reg     <= 14'(s8_x_reg.sat)
                             * 14'(6'(hrc_pkg::SECTOR_DEG) - s8_rem_reg);
            s9_pnum_reg   <= 16'(s8_x_reg.val)
                             * 16'(hrc_pkg::FULL_SCALE - s8_x_reg.sat);
        end
    end

    // ---------------- stage 10: divide by 60 and by 255 ----------------
    hrc_pkg::hrc_carry_t s10_carry_reg;
    logic [7:0]          s10_v_reg;
    logic                s10_szero_reg;
    logic [3:0]          s10_sector_reg;
    logic [7:0]          s10_a_reg;
    logic [7:0]          s10_b_reg;
    logic [7:0]          s10_p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_carry_reg  <= s9_carry_reg;
            s10_v_reg      <= s9_v_reg;
            s10_szero_reg  <= s9_szero_reg;
            s10_sector_reg <= s9_sector_reg;
            s10_a_reg      <= hrc_pkg::div60(s9_sr_reg);
            s10_b_reg      <= hrc_pkg::div60(s9_st_reg);
            s10_p_reg      <= hrc_pkg::div255(s9_pnum_reg);
        end
    end

    // ---------------- stage 11: q and t numerators ----------------
    hrc_pkg::hrc_carry_t s11_carry_reg;
    logic [7:0]          s11_v_reg;
    logic                s11_szero_reg;
    logic [3:0]          s11_sector_reg;
    logic [7:0]          s11_p_reg;
    logic [15:0]         s11_qn_reg;
    logic [15:0]         s11_tn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_carry_reg  <= s10_carry_reg;
            s11_v_reg      <= s10_v_reg;
            s11_szero_reg  <= s10_szero_reg;
            s11_sector_reg <= s10_sector_reg;
            s11_p_reg      <= s10_p_reg;
            s11_qn_reg     <= 16'(s10_v_reg) * 16'(hrc_pkg::FULL_SCALE - s10_a_reg);
            s11_tn_reg     <= 16'(s10_v_reg) * 16'(hrc_pkg::FULL_SCALE - s10_b_reg);
        end
    end

    // ---------------- stage 12: sector mux into the output word ----------------
    logic [7:0] qv, tv, pv, vv;
    logic [7:0] r_next, g_next, b_next;

    assign qv = hrc_pkg::div255(s11_qn_reg);
    assign tv = hrc_pkg::div255(s11_tn_reg);
    assign pv = s11_p_reg;
    assign vv = s11_v_reg;

    always_comb
    begin
        if (s11_szero_reg)
        begin
            r_next = vv;
            g_next = vv;
            b_next = vv;
        end
        else
        begin
            case (s11_sector_reg)
                4'd0:
                begin
                    r_next = vv; g_next = tv; b_next = pv;
                end
                4'd1:
                begin
                    r_next = qv; g_next = vv; b_next = pv;
                end
                4'd2:
                begin
                    r_next = pv; g_next = vv; b_next = tv;
                end
                4'd3:
                begin
                    r_next = pv; g_next = qv; b_next = vv;
                end
                4'd4:
                begin
                    r_next = tv; g_next = pv; b_next = vv;
                end
                // sector five and any out-of-range hue
                default:
                begin
                    r_next = vv; g_next = pv; b_next = qv;
                end
            endcase
        end
        // rgb only for hsv to rgb and vivid
        if (s11_carry_reg.act != hrc_pkg::ACT_TO_RGB && s11_carry_reg.act != hrc_pkg::ACT_VIVID)
        begin
            r_next = '0;
            g_next = '0;
            b_next = '0;
        end
    end

    hrc_pkg::hrc_hsv_t out_hsv_reg;
    logic [7:0]        out_r_reg, out_g_reg, out_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hsv_reg <= s11_carry_reg.hsv;
            out_r_reg   <= r_next;
            out_g_reg   <= g_next;
            out_b_reg   <= b_next;
        end
    end

    assign m_tdata = {7'd0, out_b_reg, out_g_reg, out_r_reg,
                      out_hsv_reg.val, out_hsv_reg.sat, out_hsv_reg.hue};

endmodule

[rtl/hrc_checker.sv]
// ----------------------------------------------------------------------------
// hrc_checker
// port-level checks for the color converter, bound to the top level
// ----------------------------------------------------------------------------
module hrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [7:0]  cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a held word stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // hue out stays inside one turn
    a_hue: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[8:0] <= 9'd359)
        else $error("hue out of range");

    // pad bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[55:49] == 7'd0)
        else $error("pad bits set");

    // an action fills either the hsv half or the rgb half, never both
    a_half: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[24:0] == 25'd0) || (m_tdata[48:25] == 24'd0))
        else $error("hsv and rgb fields both set");

    // while the output is stalled no new word can enter
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

bind hsv_rgb_color_converter_top hrc_checker u_hrc_checker (.*);
